// File: hw/rtl/acfc_pkg.sv
`default_nettype none

package acfc_pkg;

    localparam logic [9:0]  ANGLE_LIMIT  = 10'd360;
    localparam logic [15:0] COL_INVALID  = 16'h0001;
    localparam logic [15:0] FACE_BASE    = 16'h0001;
    localparam logic [15:0] FACE_HOUR    = 16'h0003;
    localparam logic [15:0] FACE_QUARTER = 16'h0007;
    localparam logic [15:0] HAND_SEC     = ~(16'hFFFF >> 13);
    localparam logic [15:0] HAND_MIN     = ~(16'hFFFF >> 10);
    localparam logic [15:0] HAND_HOUR    = ~(16'hFFFF >> 6);

    localparam int          TICK_SHIFT   = 16;
    localparam logic [11:0] RECIP_30     = 12'd2185;
    localparam logic [9:0]  RECIP_90     = 10'd729;

    typedef struct packed {
        logic       valid;
        logic       invalid;
        logic [8:0] quot;
        logic [8:0] h_sec;
        logic [8:0] h_min;
        logic [8:0] h_hour;
    } t_prep;

    typedef struct packed {
        logic       valid;
        logic       invalid;
        logic [8:0] col_angle;
        logic [8:0] tick_angle;
        logic [8:0] h_sec;
        logic [8:0] h_min;
        logic [8:0] h_hour;
    } t_col;

    typedef struct packed {
        logic       valid;
        logic       invalid;
        logic [8:0] tick_angle;
        logic [3:0] q30;
        logic [2:0] q90;
        logic       hit_sec;
        logic       hit_min;
        logic       hit_hour;
    } t_loc;

    // Maps 360 - x into 0..359 for x in 0..720.
    function automatic logic [8:0] wrap_hand(input logic [9:0] x);
        logic [8:0] r;
        if (x == 10'd0) begin
            r = 9'd0;
        end else if (x <= 10'd360) begin
            r = 9'(10'd360 - x);
        end else begin
            r = 9'(11'd720 - {1'b0, x});
        end
        return r;
    endfunction

    function automatic logic near_hand(input logic [8:0] a, input logic [8:0] h);
        logic [9:0] a1;
        logic [9:0] h1;
        a1 = {1'b0, a} + 10'd1;
        h1 = {1'b0, h} + 10'd1;
        return (a == h) || ({1'b0, a} == h1) || ({1'b0, h} == a1);
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/acfc_prep.sv
`default_nettype none

module acfc_prep
    import acfc_pkg::*;
#(
    parameter int POSITIONS = 180
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [9:0] i_angle_deg,
    input  wire logic [4:0] i_hours,
    input  wire logic [5:0] i_minutes,
    input  wire logic [5:0] i_seconds,
    output t_prep           o_prep
);

    localparam int COL_W_RAW = 360 / POSITIONS;
    localparam int COL_W     = (COL_W_RAW > 0) ? COL_W_RAW : 1;
    localparam int QSHIFT    = 20;
    localparam logic [20:0] RECIP_W = 21'(((1 << QSHIFT) + COL_W - 1) / COL_W);

    t_prep      r_prep;
    t_prep      n_prep;
    logic [29:0] prod;
    logic [4:0]  hmod;
    logic [9:0]  hour_off;

    always_comb begin
        prod = {21'd0, i_angle_deg[8:0]} * {9'd0, RECIP_W};
        if (i_hours >= 5'd24) begin
            hmod = i_hours - 5'd24;
        end else if (i_hours >= 5'd12) begin
            hmod = i_hours - 5'd12;
        end else begin
            hmod = i_hours;
        end
        hour_off = 10'(hmod * 10'd30) + {5'd0, i_minutes[5:1]};

        n_prep.valid   = i_start;
        n_prep.invalid = (i_angle_deg >= ANGLE_LIMIT);
        n_prep.quot    = prod[QSHIFT +: 9];
        n_prep.h_sec   = wrap_hand(10'(i_seconds * 10'd6));
        n_prep.h_min   = wrap_hand(10'(i_minutes * 10'd6));
        n_prep.h_hour  = wrap_hand(hour_off);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep.valid <= 1'b0;
        end else begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

`default_nettype wire

// File: hw/rtl/acfc_locate.sv
`default_nettype none

module acfc_locate
    import acfc_pkg::*;
#(
    parameter int POSITIONS = 180
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_prep     i_prep,
    output t_loc      o_loc
);

    localparam int COL_W_RAW = 360 / POSITIONS;
    localparam int COL_W     = (COL_W_RAW > 0) ? COL_W_RAW : 1;
    localparam logic [8:0] COL_W_V = 9'(COL_W);

    t_col        r_col;
    t_col        n_col;
    t_loc        r_loc;
    t_loc        n_loc;
    logic [17:0] col_prod;
    logic [20:0] p30;
    logic [18:0] p90;

    always_comb begin
        col_prod          = {9'd0, i_prep.quot} * {9'd0, COL_W_V};
        n_col.valid       = i_prep.valid;
        n_col.invalid     = i_prep.invalid;
        n_col.col_angle   = col_prod[8:0];
        n_col.tick_angle  = col_prod[8:0] + 9'd2;
        n_col.h_sec       = i_prep.h_sec;
        n_col.h_min       = i_prep.h_min;
        n_col.h_hour      = i_prep.h_hour;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col.valid <= 1'b0;
        end else begin
            r_col <= n_col;
        end
    end

    always_comb begin
        p30 = {12'd0, r_col.tick_angle} * {9'd0, RECIP_30};
        p90 = {10'd0, r_col.tick_angle} * {9'd0, RECIP_90};
        n_loc.valid      = r_col.valid;
        n_loc.invalid    = r_col.invalid;
        n_loc.tick_angle = r_col.tick_angle;
        n_loc.q30        = p30[TICK_SHIFT +: 4];
        n_loc.q90        = p90[TICK_SHIFT +: 3];
        n_loc.hit_sec    = near_hand(r_col.col_angle, r_col.h_sec);
        n_loc.hit_min    = near_hand(r_col.col_angle, r_col.h_min);
        n_loc.hit_hour   = near_hand(r_col.col_angle, r_col.h_hour);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loc.valid <= 1'b0;
        end else begin
            r_loc <= n_loc;
        end
    end

    assign o_loc = r_loc;

endmodule

`default_nettype wire

// File: hw/rtl/acfc_draw.sv
`default_nettype none

module acfc_draw
    import acfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_loc             i_loc,
    output logic             o_done,
    output logic [15:0]      o_led_column
);

    logic        r_done;
    logic [15:0] r_led_column;
    logic [15:0] n_led_column;
    logic [8:0]  r30;
    logic [8:0]  r90;

    always_comb begin
        r30 = i_loc.tick_angle - 9'(i_loc.q30 * 9'd30);
        r90 = i_loc.tick_angle - 9'(i_loc.q90 * 9'd90);
        n_led_column = FACE_BASE;
        if (r30 < 9'd4) begin
            n_led_column = n_led_column | FACE_HOUR;
        end
        if (r90 < 9'd4) begin
            n_led_column = n_led_column | FACE_QUARTER;
        end
        if (i_loc.hit_sec) begin
            n_led_column = n_led_column | HAND_SEC;
        end
        if (i_loc.hit_min) begin
            n_led_column = n_led_column | HAND_MIN;
        end
        if (i_loc.hit_hour) begin
            n_led_column = n_led_column | HAND_HOUR;
        end
        if (i_loc.invalid) begin
            n_led_column = COL_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_loc.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_led_column <= n_led_column;
    end

    assign o_done       = r_done;
    assign o_led_column = r_led_column;

endmodule

`default_nettype wire

// File: hw/rtl/analog_clock_face_column.sv
// Channel   Direction  Handshake                  Payload
// request   in         start while !busy          i_angle_deg, i_hours, i_minutes, i_seconds
// column    out        o_done, one-cycle strobe   o_led_column
//
// A transaction is taken in every cycle; busy is always low.
// Each column appears on o_done once its request has passed the register stages below.
// The four register stages are the input stage with the column quantizing
// multiply, the column angle, the tick quotients with the hand compares,
// and the output register. The synchronous reset clears the valid bits.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module analog_clock_face_column
    import acfc_pkg::*;
#(
    parameter int POSITIONS = 180
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [9:0]  i_angle_deg,
    input  wire logic [4:0]  i_hours,
    input  wire logic [5:0]  i_minutes,
    input  wire logic [5:0]  i_seconds,
    output logic             o_done,
    output logic [15:0]      o_led_column
);

    t_prep prep;
    t_loc  loc;

    assign busy = 1'b0;

    acfc_prep #(
        .POSITIONS (POSITIONS)
    ) u_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_angle_deg (i_angle_deg),
        .i_hours     (i_hours),
        .i_minutes   (i_minutes),
        .i_seconds   (i_seconds),
        .o_prep      (prep)
    );

    acfc_locate #(
        .POSITIONS (POSITIONS)
    ) u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prep  (prep),
        .o_loc   (loc)
    );

    acfc_draw u_draw (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_loc        (loc),
        .o_done       (o_done),
        .o_led_column (o_led_column)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int POSITIONS   = 180;
    localparam int STALL_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [9:0] angle;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } t_column_req;

    typedef struct packed {
        t_column_req req;
        logic [15:0] col;
    } t_column_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [9:0]  i_angle_deg = '0;
    logic [4:0]  i_hours = '0;
    logic [5:0]  i_minutes = '0;
    logic [5:0]  i_seconds = '0;
    logic        busy;
    logic        o_done;
    logic [15:0] o_led_column;

    t_column_req pending_q[$];
    t_column_exp column_exp_q[$];
    t_column_req cur_req = '0;
    int          idle_pct = 0;
    int          burst_left = 0;
    int          n_errors = 0;
    int          stall_cycles = 0;

    analog_clock_face_column #(
        .POSITIONS(POSITIONS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_angle_deg (i_angle_deg),
        .i_hours     (i_hours),
        .i_minutes   (i_minutes),
        .i_seconds   (i_seconds),
        .o_done      (o_done),
        .o_led_column(o_led_column)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int hand_angle(input int offset);
        int r;
        r = (360 - offset) % 360;
        if (r < 0) r += 360;
        return r;
    endfunction

    function automatic logic [15:0] hand_mask(input int a, input int h, input int len);
        int d;
        d = (a > h) ? a - h : h - a;
        return (d < 2) ? (16'hFFFF ^ (16'hFFFF >> len)) : 16'h0000;
    endfunction

    function automatic logic [15:0] predict_column(input t_column_req r);
        int          w;
        int          a;
        logic [15:0] col;
        if (r.angle >= 10'd360) return 16'h0001;
        w = 360 / POSITIONS;
        if (w == 0) w = 1;
        a = (int'(r.angle) / w) * w;
        col = 16'h0001;
        if ((a + 2) % 30 < 4) col |= 16'h0003;
        if ((a + 2) % 90 < 4) col |= 16'h0007;
        col |= hand_mask(a, hand_angle(6 * int'(r.seconds)), 13);
        col |= hand_mask(a, hand_angle(6 * int'(r.minutes)), 10);
        col |= hand_mask(a, hand_angle(30 * (int'(r.hours) % 12) + int'(r.minutes) / 2), 6);
        return col;
    endfunction

    // Many angles are steered toward hands and ticks so that the compares
    // are exercised on both sides of their thresholds.
    function automatic t_column_req random_req();
        t_column_req r;
        int          pick;
        int          h;
        pick = $urandom_range(99);
        r.hours   = ($urandom_range(99) < 85) ? 5'($urandom_range(23)) : 5'($urandom_range(31));
        r.minutes = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
        r.seconds = ($urandom_range(99) < 85) ? 6'($urandom_range(59)) : 6'($urandom_range(63));
        if (pick < 35) begin
            r.angle = 10'($urandom_range(359));
        end else if (pick < 82) begin
            if (pick < 70) begin
                case ($urandom_range(2))
                    0: h = hand_angle(6 * int'(r.seconds));
                    1: h = hand_angle(6 * int'(r.minutes));
                    default: h = hand_angle(30 * (int'(r.hours) % 12) + int'(r.minutes) / 2);
                endcase
            end else begin
                h = 30 * int'($urandom_range(11));
            end
            h = h + int'($urandom_range(6)) - 3;
            if (h < 0) h += 360;
            if (h > 359) h -= 360;
            r.angle = 10'(h);
        end else if (pick < 92) begin
            r.angle = 10'($urandom_range(1023, 360));
        end else begin
            r.angle = 10'($urandom_range(1023));
        end
        return r;
    endfunction

    task automatic add_req(input int angle, input int hours, input int minutes, input int seconds);
        t_column_req r;
        r.angle   = 10'(angle);
        r.hours   = 5'(hours);
        r.minutes = 6'(minutes);
        r.seconds = 6'(seconds);
        pending_q.push_back(r);
    endtask

    task automatic add_random(input int count);
        for (int k = 0; k < count; k++) begin
            pending_q.push_back(random_req());
        end
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_q.size() != 0 || start || column_exp_q.size() != 0);
    endtask

    always @(posedge i_clk) begin : drive_proc
        logic go;
        go = start;
        if (!i_rst_n) begin
            go = 1'b0;
        end else begin
            if (start && !busy) begin
                column_exp_q.push_back('{req: cur_req, col: predict_column(cur_req)});
                go = 1'b0;
            end
            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(63) == 0) begin
                burst_left = 20;
            end
            if (!go && pending_q.size() != 0 &&
                (burst_left > 0 || $urandom_range(99) >= idle_pct)) begin
                cur_req = pending_q.pop_front();
                go = 1'b1;
            end
        end
        start       <= go;
        i_angle_deg <= cur_req.angle;
        i_hours     <= cur_req.hours;
        i_minutes   <= cur_req.minutes;
        i_seconds   <= cur_req.seconds;
    end

    always @(posedge i_clk) begin : check_proc
        t_column_exp e;
        if (i_rst_n && o_done) begin
            if (column_exp_q.size() == 0) begin
                n_errors++;
                if (n_errors <= SHOW_LIMIT)
                    $display("Unexpected column %h with no transaction pending", o_led_column);
            end else begin
                e = column_exp_q.pop_front();
                if (o_led_column !== e.col) begin
                    n_errors++;
                    if (n_errors <= SHOW_LIMIT)
                        $display("Column mismatch: angle %0d time %0d:%0d:%0d expected %h got %h",
                                 e.req.angle, e.req.hours, e.req.minutes, e.req.seconds,
                                 e.col, o_led_column);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 0;
        add_req(0, 0, 0, 0);
        add_req(1, 0, 0, 0);
        add_req(359, 0, 0, 0);
        add_req(358, 0, 0, 0);
        add_req(360, 0, 0, 0);
        add_req(1023, 31, 63, 63);
        add_req(28, 3, 0, 0);
        add_req(30, 3, 0, 0);
        add_req(32, 3, 0, 0);
        add_req(88, 3, 0, 0);
        add_req(90, 3, 0, 0);
        add_req(92, 3, 0, 0);
        add_req(342, 31, 63, 63);
        add_req(119, 31, 63, 63);
        add_req(120, 31, 63, 63);
        add_req(300, 2, 10, 10);
        add_req(296, 2, 10, 10);
        add_req(294, 2, 10, 10);
        add_req(0, 12, 0, 30);
        add_req(180, 12, 0, 30);
        add_req(181, 23, 59, 59);
        add_req(6, 23, 59, 59);
        add_req(2, 23, 59, 59);
        add_random(75);
        wait_drained();

        idle_pct = 57;
        add_random(100);
        wait_drained();

        idle_pct = 0;
        add_random(100);
        wait_drained();

        idle_pct = 23;
        add_random(100);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0 && column_exp_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/acfc_pkg.sv
hw/rtl/acfc_prep.sv
hw/rtl/acfc_locate.sv
hw/rtl/acfc_draw.sv
hw/rtl/analog_clock_face_column.sv
tb/testbench.sv
